// File: rtl/rmv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running mean and variance: shared package
// Widths, limits and the command structs for the serial divider and
// multiplier.
// ----------------------------------------------------------------------------
package rmv_pkg;

	localparam int DATA_W     = 32;                 // sample and mean
	localparam int CNT_W      = 21;                 // sample count
	localparam int SUM_W      = 63;                 // saturated deviation sum
	localparam int DIV_W      = 64;                 // divider dividend/quotient
	localparam int MUL_W      = 32;                 // multiplier operand shifter
	localparam int PROD_W     = 64;                 // multiplier accumulator
	localparam int DIV_STEP_W = $clog2(DIV_W + 1);
	localparam int MUL_STEP_W = $clog2(MUL_W + 1);

	localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(1048576);

	typedef struct packed {
		logic                  start;
		logic [DIV_STEP_W-1:0] steps;
	} div_cmd_t;

	typedef struct packed {
		logic                  start;
		logic                  sat_in;
		logic [MUL_STEP_W-1:0] steps;
	} mul_cmd_t;

endpackage

// File: rtl/running_mean_variance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running mean and variance: top level
// One-pass mean and sample variance of a stream of Q15.16 samples, using a
// bit-serial divider and a bit-serial multiplier under a small sequencer.
// ----------------------------------------------------------------------------
//  channel   valid       stall       words
//  input     smp_valid   smp_stall   sample, last
//  result    res_valid   res_stall   mean, variance, sample_count, overflow
//
// The first sample of a run only sets the mean and the count. Each later
// sample runs a 32-step division for the mean step, then multiplications of
// 32, 21 and 21 steps for the squared, count-weighted term.
// A last word adds the 64-step variance division when the count is above one.
// Reset clears the run state and the result register.
// A waiting result does not block the input; only the next result does.
// ----------------------------------------------------------------------------
module running_mean_variance (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          smp_valid,
	output logic                          smp_stall,
	input  logic signed [31:0]            sample,
	input  logic                          last,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic signed [31:0]            mean,
	output logic [62:0]                   variance,
	output logic [20:0]                   sample_count,
	output logic                          overflow
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_START,
		S_DIV,
		S_SQ,
		S_MK,
		S_MK1,
		S_FIN,
		S_VDIV,
		S_OUT
	} state_t;

	state_t state_q;

	logic signed [rmv_pkg::DATA_W-1:0] sample_q;
	logic                              last_q;
	logic signed [rmv_pkg::DATA_W-1:0] mean_q;
	logic [rmv_pkg::SUM_W-1:0]         sum_q;
	logic [rmv_pkg::CNT_W-1:0]         count_q;
	logic                              ovf_q;
	logic [rmv_pkg::CNT_W-1:0]         k_q;
	logic                              neg_q;
	logic [rmv_pkg::DATA_W-1:0]        a_q;
	logic [rmv_pkg::SUM_W-1:0]         var_q;

	logic signed [rmv_pkg::DATA_W-1:0] res_mean_q;
	logic [rmv_pkg::SUM_W-1:0]         res_var_q;
	logic [rmv_pkg::CNT_W-1:0]         res_count_q;
	logic                              res_ovf_q;
	logic                              res_valid_q;

	rmv_pkg::div_cmd_t            div_cmd;
	logic [rmv_pkg::DIV_W-1:0]    div_dividend;
	logic [rmv_pkg::CNT_W-1:0]    div_divisor;
	logic [rmv_pkg::DIV_W-1:0]    div_quot;
	logic                         div_done;

	rmv_pkg::mul_cmd_t            mul_cmd;
	logic [rmv_pkg::PROD_W-1:0]   mul_mcand;
	logic [rmv_pkg::MUL_W-1:0]    mul_mplier;
	logic [rmv_pkg::PROD_W-1:0]   mul_prod;
	logic                         mul_sat;
	logic                         mul_done;

	logic                         smp_take;
	logic                         res_free;
	logic                         run_step;
	logic [rmv_pkg::DATA_W:0]     diff;
	logic [rmv_pkg::DATA_W:0]     diff_mag;
	logic [rmv_pkg::DATA_W-1:0]   dx;
	logic [rmv_pkg::SUM_W:0]      sum_nxt;

	assign smp_stall = (state_q != S_IDLE);
	assign smp_take  = smp_valid && !smp_stall;
	assign res_free  = !res_valid_q || !res_stall;

	// A normal update needs a run in progress that is below the count limit.
	assign run_step = (count_q != '0) && (count_q < rmv_pkg::MAX_COUNT);

	assign diff     = {sample_q[rmv_pkg::DATA_W-1], sample_q}
		- {mean_q[rmv_pkg::DATA_W-1], mean_q};
	assign diff_mag = diff[rmv_pkg::DATA_W] ? -diff : diff;
	assign dx       = neg_q ? -a_q : a_q;
	assign sum_nxt  = {1'b0, sum_q} + mul_prod[rmv_pkg::SUM_W:0];

	always_comb begin
		div_cmd.start = ((state_q == S_START) && run_step)
			|| ((state_q == S_FIN) && (count_q > rmv_pkg::CNT_W'(1)));
		if (state_q == S_FIN) begin
			div_cmd.steps = rmv_pkg::DIV_STEP_W'(rmv_pkg::DIV_W);
			div_dividend  = {1'b0, sum_q};
			div_divisor   = count_q - 1'b1;
		end else begin
			div_cmd.steps = rmv_pkg::DIV_STEP_W'(rmv_pkg::DATA_W);
			div_dividend  = {diff_mag[rmv_pkg::DATA_W-1:0],
				{(rmv_pkg::DIV_W-rmv_pkg::DATA_W){1'b0}}};
			div_divisor   = count_q + 1'b1;
		end
	end

	always_comb begin
		mul_cmd.start = ((state_q == S_DIV) && div_done)
			|| ((state_q == S_SQ) && mul_done)
			|| ((state_q == S_MK) && mul_done);
		case (state_q)
			S_DIV: begin
				mul_cmd.steps  = rmv_pkg::MUL_STEP_W'(rmv_pkg::DATA_W);
				mul_cmd.sat_in = 1'b0;
				mul_mcand      = {{(rmv_pkg::PROD_W-rmv_pkg::DATA_W){1'b0}},
					div_quot[rmv_pkg::DATA_W-1:0]};
				mul_mplier     = div_quot[rmv_pkg::DATA_W-1:0];
			end
			S_SQ: begin
				mul_cmd.steps  = rmv_pkg::MUL_STEP_W'(rmv_pkg::CNT_W);
				mul_cmd.sat_in = mul_sat;
				mul_mcand      = mul_prod;
				mul_mplier     = {k_q, {(rmv_pkg::MUL_W-rmv_pkg::CNT_W){1'b0}}};
			end
			default: begin
				// k - 1 is the count before this sample is taken.
				mul_cmd.steps  = rmv_pkg::MUL_STEP_W'(rmv_pkg::CNT_W);
				mul_cmd.sat_in = mul_sat;
				mul_mcand      = mul_prod;
				mul_mplier     = {count_q, {(rmv_pkg::MUL_W-rmv_pkg::CNT_W){1'b0}}};
			end
		endcase
	end

	rmv_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (div_cmd),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quot),
		.done     (div_done)
	);

	rmv_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (mul_cmd),
		.mcand   (mul_mcand),
		.mplier  (mul_mplier),
		.product (mul_prod),
		.sat     (mul_sat),
		.done    (mul_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sample_q    <= '0;
			last_q      <= 1'b0;
			mean_q      <= '0;
			sum_q       <= '0;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			k_q         <= '0;
			neg_q       <= 1'b0;
			a_q         <= '0;
			var_q       <= '0;
			res_mean_q  <= '0;
			res_var_q   <= '0;
			res_count_q <= '0;
			res_ovf_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			// In S_OUT a freed result register is refilled below instead.
			if (res_valid_q && !res_stall && (state_q != S_OUT)) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (smp_take) begin
						sample_q <= sample;
						last_q   <= last;
						state_q  <= S_START;
					end
				end
				S_START: begin
					if (count_q == '0) begin
						mean_q  <= sample_q;
						sum_q   <= '0;
						count_q <= rmv_pkg::CNT_W'(1);
						state_q <= last_q ? S_FIN : S_IDLE;
					end else if (!run_step) begin
						// Past the count limit the word only marks the run.
						ovf_q   <= 1'b1;
						state_q <= last_q ? S_FIN : S_IDLE;
					end else begin
						k_q     <= count_q + 1'b1;
						neg_q   <= diff[rmv_pkg::DATA_W];
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						a_q     <= div_quot[rmv_pkg::DATA_W-1:0];
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					if (mul_done) begin
						state_q <= S_MK;
					end
				end
				S_MK: begin
					if (mul_done) begin
						state_q <= S_MK1;
					end
				end
				S_MK1: begin
					if (mul_done) begin
						if (mul_sat || sum_nxt[rmv_pkg::SUM_W]) begin
							sum_q <= '1;
							ovf_q <= 1'b1;
						end else begin
							sum_q <= sum_nxt[rmv_pkg::SUM_W-1:0];
						end
						mean_q  <= mean_q + dx;
						count_q <= k_q;
						state_q <= last_q ? S_FIN : S_IDLE;
					end
				end
				S_FIN: begin
					if (count_q > rmv_pkg::CNT_W'(1)) begin
						state_q <= S_VDIV;
					end else begin
						var_q   <= '0;
						state_q <= S_OUT;
					end
				end
				S_VDIV: begin
					if (div_done) begin
						var_q   <= div_quot[rmv_pkg::SUM_W-1:0];
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (res_free) begin
						res_mean_q  <= mean_q;
						res_var_q   <= var_q;
						res_count_q <= count_q;
						res_ovf_q   <= ovf_q;
						res_valid_q <= 1'b1;
						mean_q      <= '0;
						sum_q       <= '0;
						count_q     <= '0;
						ovf_q       <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res_valid    = res_valid_q;
	assign mean         = res_mean_q;
	assign variance     = res_var_q;
	assign sample_count = res_count_q;
	assign overflow     = res_ovf_q;

endmodule

// File: rtl/rmv_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running mean and variance: serial divider
// Restoring unsigned division, one quotient bit per cycle. The dividend is
// left aligned; after N steps the low N bits of the quotient register hold
// the quotient.
// ----------------------------------------------------------------------------
module rmv_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rmv_pkg::div_cmd_t            cmd,
	input  logic [rmv_pkg::DIV_W-1:0]    dividend,
	input  logic [rmv_pkg::CNT_W-1:0]    divisor,
	output logic [rmv_pkg::DIV_W-1:0]    quotient,
	output logic                         done
);

	logic [rmv_pkg::CNT_W-1:0]      rem_q;
	logic [rmv_pkg::CNT_W-1:0]      dvs_q;
	logic [rmv_pkg::DIV_W-1:0]      quo_q;
	logic [rmv_pkg::DIV_STEP_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;

	logic [rmv_pkg::CNT_W:0] trial;
	logic [rmv_pkg::CNT_W:0] trial_sub;
	logic                    ge;

	assign trial     = {rem_q, quo_q[rmv_pkg::DIV_W-1]};
	assign ge        = trial >= {1'b0, dvs_q};
	assign trial_sub = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			dvs_q  <= '0;
			quo_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				rem_q  <= '0;
				dvs_q  <= divisor;
				quo_q  <= dividend;
				cnt_q  <= cmd.steps;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				// The remainder stays below the divisor, so it fits CNT_W bits.
				rem_q <= ge ? trial_sub[rmv_pkg::CNT_W-1:0] : trial[rmv_pkg::CNT_W-1:0];
				quo_q <= {quo_q[rmv_pkg::DIV_W-2:0], ge};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == rmv_pkg::DIV_STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

// File: rtl/rmv_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running mean and variance: serial multiplier
// Shift-and-add multiply, one multiplier bit per cycle, most significant bit
// first. A sticky flag marks any product that reaches 2^63.
// ----------------------------------------------------------------------------
module rmv_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rmv_pkg::mul_cmd_t             cmd,
	input  logic [rmv_pkg::PROD_W-1:0]    mcand,
	input  logic [rmv_pkg::MUL_W-1:0]     mplier,
	output logic [rmv_pkg::PROD_W-1:0]    product,
	output logic                          sat,
	output logic                          done
);

	logic [rmv_pkg::PROD_W-1:0]     mcand_q;
	logic [rmv_pkg::PROD_W-1:0]     acc_q;
	logic [rmv_pkg::MUL_W-1:0]      bits_q;
	logic [rmv_pkg::MUL_STEP_W-1:0] cnt_q;
	logic                           sat_q;
	logic                           busy_q;
	logic                           done_q;

	logic [rmv_pkg::PROD_W+1:0] acc_nxt;

	// Partial products only grow, so once the sum reaches 2^63 it stays there.
	assign acc_nxt = {1'b0, acc_q, 1'b0}
		+ (bits_q[rmv_pkg::MUL_W-1] ? {2'b00, mcand_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mcand_q <= '0;
			acc_q   <= '0;
			bits_q  <= '0;
			cnt_q   <= '0;
			sat_q   <= 1'b0;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				mcand_q <= mcand;
				acc_q   <= '0;
				bits_q  <= mplier;
				cnt_q   <= cmd.steps;
				sat_q   <= cmd.sat_in;
				busy_q  <= 1'b1;
			end else if (busy_q) begin
				if (!sat_q) begin
					acc_q <= acc_nxt[rmv_pkg::PROD_W-1:0];
					if (|acc_nxt[rmv_pkg::PROD_W+1:rmv_pkg::PROD_W-1]) begin
						sat_q <= 1'b1;
					end
				end
				bits_q <= {bits_q[rmv_pkg::MUL_W-2:0], 1'b0};
				cnt_q  <= cnt_q - 1'b1;
				if (cnt_q == rmv_pkg::MUL_STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign product = acc_q;
	assign sat     = sat_q;
	assign done    = done_q;

endmodule
